[rtl/dvt_pkg.sv]
// ----------------------------------------------------------------------------
// dvt_pkg
// Shared types and constants for the distance-vector table update block.
// ----------------------------------------------------------------------------
package dvt_pkg;

  localparam int NODE_W = 4;
  localparam int COST_W = 14;
  localparam int AGE_W  = 16;
  localparam int MASK_W = 16;

  localparam logic [COST_W-1:0] COST_INF = 14'd10000;
  localparam logic [AGE_W-1:0]  AGE_MAX  = 16'hFFFF;

  // Stream data widths, rounded up to whole bytes, and the two-bit user width.
  localparam int S_DATA_W = 24;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    REQ_ADVERT = 2'd0,
    REQ_LINK   = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_READ   = 2'd3
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SELF_ID = 2'd0,
    CFG_NBR_MASK = 2'd1,
    CFG_TIMEOUT = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

endpackage

[rtl/distance_vector_table_update_top.sv]
// ----------------------------------------------------------------------------
// distance_vector_table_update_top
// Distance-vector routing table with Bellman-Ford relaxation.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream: tuser carries the request kind (advertised
// entry, link-cost write, tick, read) and tdata carries sender, destination
// and cost. Only a read produces a beat on the m_ stream, holding the node,
// its next hop, its cost and an unreachable flag.
// Configuration registers (self id, neighbor mask, timeout) are written over
// the cfg_ channel, which is always ready; write them only while idle.
// Path costs and next hops live in two synchronous memories of MAX_NODES
// entries. Each request reads the sender and destination entries in the idle
// state, then adds, compares and writes back in the execute state. A new
// request is taken only after the previous one has left the execute state. A
// read result is registered at write-back and then appears on m_tdata.
// Neighbor ages and timed-out flags sit in flip-flops and are updated in
// parallel. Reset restores the registers, clears ages and flags, and clears
// the per-entry valid bits, so the tables read as infinity cost and next hop
// equal to the entry number; no clearing pass is needed.
// When m_tready is low with a result pending, a following read waits in the
// execute state and s_tready stays low until the result beat is taken.
// ----------------------------------------------------------------------------
module distance_vector_table_update_top #(
  parameter int MAX_NODES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata: sender_node[3:0], dest_node[7:4], cost_value[21:8], zero pad
  input  logic [dvt_pkg::S_DATA_W-1:0]  s_tdata,
  // s_tuser: req_type[1:0]
  input  logic [dvt_pkg::S_USER_W-1:0]  s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata: read_node[3:0], read_next_hop[7:4], read_cost[21:8],
  //          read_infinite[22], zero pad
  output logic [dvt_pkg::M_DATA_W-1:0]  m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dvt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dvt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dvt_pkg::*;

  localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NBR_N = (MAX_NODES < 16) ? MAX_NODES : 16;
  localparam int NBR_IDX_W = (NBR_N > 1) ? $clog2(NBR_N) : 1;

  // Configuration registers.
  logic [NODE_W-1:0] self_id;
  logic [MASK_W-1:0] neighbor_mask;
  logic [AGE_W-1:0]  timeout_ticks;

  // Registered request.
  state_t            state, state_next;
  req_type_t         req_type;
  logic [NODE_W-1:0] snd;
  logic [NODE_W-1:0] dst;
  logic [COST_W-1:0] cost;
  logic              snd_in, dst_in;

  // Tables and their read data.
  logic [COST_W-1:0] cost_mem [MAX_NODES];
  logic [NODE_W-1:0] hop_mem  [MAX_NODES];
  logic [MAX_NODES-1:0] cost_vld, hop_vld;
  logic [COST_W-1:0] cost_rd_snd, cost_rd_dst;
  logic [NODE_W-1:0] hop_rd_dst;
  logic              cvld_snd, cvld_dst, hvld_dst;

  // Neighbor aging.
  logic [AGE_W-1:0]  nbr_age [NBR_N];
  logic [NBR_N-1:0]  nbr_to;

  // Output register.
  logic [NODE_W-1:0] out_node, out_hop;
  logic [COST_W-1:0] out_cost;
  logic              out_inf;

  logic              s_acc;
  logic              exec_go;
  logic [NODE_W-1:0] in_snd, in_dst;
  logic [COST_W-1:0] in_cost_raw, in_cost;
  logic              in_snd_ok, in_dst_ok;

  logic [COST_W-1:0] via, cur_dst, cand;
  logic [COST_W:0]   sum;
  logic              is_self, dst_to;
  logic              mem_we, hop_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [COST_W-1:0] mem_wcost;
  logic [NODE_W-1:0] hop_dst;
  logic [NODE_W-1:0] rd_hop;
  logic [COST_W-1:0] rd_cost;
  logic              rd_inf;

  assign cfg_ready = 1'b1;

  assign in_snd      = s_tdata[NODE_W-1:0];
  assign in_dst      = s_tdata[2*NODE_W-1:NODE_W];
  assign in_cost_raw = s_tdata[2*NODE_W+COST_W-1:2*NODE_W];
  assign in_cost     = (in_cost_raw > COST_INF) ? COST_INF : in_cost_raw;
  assign in_snd_ok   = (32'(in_snd) < MAX_NODES);
  assign in_dst_ok   = (32'(in_dst) < MAX_NODES);
  assign s_acc       = s_tvalid && s_tready;

  // Control: accept in idle, then execute in the execute state. A read waits
  // while the previous result is still held and not taken.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    exec_go    = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!(req_type == REQ_READ && m_tvalid && !m_tready)) begin
          exec_go    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      self_id       <= NODE_W'(1);
      neighbor_mask <= '0;
      timeout_ticks <= AGE_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SELF_ID:  self_id       <= cfg_data[NODE_W-1:0];
        CFG_NBR_MASK: neighbor_mask <= cfg_data[MASK_W-1:0];
        CFG_TIMEOUT:  timeout_ticks <= cfg_data[AGE_W-1:0];
        default: ;
      endcase
    end
  end

  // Request capture and table read, both on the accept edge.
  always_ff @(posedge clk) begin
    if (s_acc) begin
      req_type    <= req_type_t'(s_tuser);
      snd         <= in_snd;
      dst         <= in_dst;
      cost        <= in_cost;
      snd_in      <= in_snd_ok;
      dst_in      <= in_dst_ok;
      cost_rd_snd <= cost_mem[IDX_W'(in_snd)];
      cost_rd_dst <= cost_mem[IDX_W'(in_dst)];
      hop_rd_dst  <= hop_mem[IDX_W'(in_dst)];
      cvld_snd    <= in_snd_ok && cost_vld[IDX_W'(in_snd)];
      cvld_dst    <= in_dst_ok && cost_vld[IDX_W'(in_dst)];
      hvld_dst    <= in_dst_ok && hop_vld[IDX_W'(in_dst)];
    end
  end

  // Relaxation, write-back selection and read result selection.
  always_comb begin
    via     = cvld_snd ? cost_rd_snd : COST_INF;
    cur_dst = cvld_dst ? cost_rd_dst : COST_INF;
    sum     = {1'b0, cost} + {1'b0, via};
    cand    = (sum > {1'b0, COST_INF}) ? COST_INF : sum[COST_W-1:0];
    is_self = (dst == self_id);
    dst_to  = dst_in && (32'(dst) < NBR_N) && nbr_to[NBR_IDX_W'(dst)];
    hop_dst = hvld_dst ? hop_rd_dst : dst;

    mem_we    = 1'b0;
    hop_we    = 1'b0;
    mem_waddr = IDX_W'(dst);
    mem_wcost = cost;
    if (exec_go) begin
      case (req_type)
        REQ_ADVERT: begin
          if (!is_self) begin
            if (dst_in && cur_dst > cand) begin
              mem_we    = 1'b1;
              hop_we    = 1'b1;
              mem_wcost = cand;
            end
          end else if (snd_in) begin
            mem_we    = 1'b1;
            mem_waddr = IDX_W'(snd);
          end
        end
        REQ_LINK: mem_we = dst_in;
        REQ_READ: begin
          // A timed-out neighbor's route is dropped when it is read.
          if (!is_self && dst_to) begin
            mem_we    = 1'b1;
            mem_wcost = COST_INF;
          end
        end
        default: ;
      endcase
    end

    if (is_self) begin
      rd_hop  = self_id;
      rd_cost = '0;
      rd_inf  = 1'b0;
    end else if (!dst_in) begin
      rd_hop  = dst;
      rd_cost = COST_INF;
      rd_inf  = 1'b1;
    end else if (dst_to || cur_dst >= COST_INF) begin
      rd_hop  = hop_dst;
      rd_cost = COST_INF;
      rd_inf  = 1'b1;
    end else begin
      rd_hop  = hop_dst;
      rd_cost = cur_dst;
      rd_inf  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cost_mem[mem_waddr] <= mem_wcost;
    end
    if (hop_we) begin
      hop_mem[mem_waddr] <= snd;
    end
  end

  // Entries not yet written read as their reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      cost_vld <= '0;
      hop_vld  <= '0;
    end else begin
      if (mem_we) begin
        cost_vld[mem_waddr] <= 1'b1;
      end
      if (hop_we) begin
        hop_vld[mem_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NBR_N; k++) begin
        nbr_age[k] <= '0;
      end
      nbr_to <= '0;
    end else if (exec_go) begin
      for (int k = 0; k < NBR_N; k++) begin
        if (req_type == REQ_ADVERT) begin
          if (32'(snd) == k) begin
            nbr_age[k] <= '0;
            nbr_to[k]  <= 1'b0;
          end else if (neighbor_mask[k] && nbr_age[k] > timeout_ticks) begin
            nbr_to[k] <= 1'b1;
          end
        end else if (req_type == REQ_TICK) begin
          if (nbr_age[k] != AGE_MAX) begin
            nbr_age[k] <= nbr_age[k] + AGE_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec_go && req_type == REQ_READ) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go && req_type == REQ_READ) begin
      out_node <= dst;
      out_hop  <= rd_hop;
      out_cost <= rd_cost;
      out_inf  <= rd_inf;
    end
  end

  assign m_tdata = {1'b0, out_inf, out_cost, out_hop, out_node};

endmodule

[dv/distance_vector_table_update_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_vector_table_update_top_test
// Self-checking bench for the distance-vector routing table block.
// ----------------------------------------------------------------------------
// A queue of route requests feeds a stream driver; every accepted request is
// applied to a local copy of the routing table. Each read is turned into an
// expected result beat. The receiver checks each result beat, field by field,
// against the oldest expected one. The run has these parts:
//   - directed requests at reset values and with a small neighbor set;
//   - random phases under several register settings, extremes included;
//   - a final tick run that times out every neighbor but one before a table dump.
// Random idle bursts are applied on both stream sides, except at the end.
// ----------------------------------------------------------------------------
module distance_vector_table_update_top_test;
  import dvt_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int NODES = 16;

  typedef struct packed {
    req_type_t   kind;
    logic [3:0]  sender;
    logic [3:0]  dest;
    logic [13:0] cost;
  } route_req_t;

  typedef struct packed {
    logic [3:0]  node;
    logic [3:0]  hop;
    logic [13:0] cost;
    logic        inf;
  } read_resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [S_USER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Local copy of the routing table and of the registers.
  logic [13:0] cost_tab [NODES];
  logic [3:0]  hop_tab  [NODES];
  logic [15:0] age_tab  [NODES];
  logic        tmo_tab  [NODES];
  logic [3:0]  my_id;
  logic [15:0] nbr_mask;
  logic [15:0] tmo_limit;

  route_req_t req_q [$];
  route_req_t req_cur;
  read_resp_t read_resp_q [$];
  read_resp_t want;

  int issued_cnt = 0;
  int accepted_cnt = 0;
  int checked_cnt = 0;
  int reg_writes = 0;
  int settings_cnt = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  bit calm = 1'b0;

  distance_vector_table_update_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report(input string what, input int seen, input int wanted);
    err_cnt++;
    if (err_cnt <= 100) begin
      $display("mismatch in %s at cycle %0d: got %0d, expected %0d",
               what, cycle_cnt, seen, wanted);
    end
  endtask

  // Applies one accepted request to the local table and queues the read
  // result it produces, if any.
  task automatic route_table_step(input route_req_t r);
    logic [13:0] c;
    logic [14:0] sum;
    read_resp_t e;
    int k;
    c = (r.cost > COST_INF) ? COST_INF : r.cost;
    case (r.kind)
      REQ_ADVERT: begin
        if (r.dest != my_id) begin
          sum = c + cost_tab[r.sender];
          if (sum > COST_INF) sum = COST_INF;
          if (cost_tab[r.dest] > sum) begin
            cost_tab[r.dest] = sum[13:0];
            hop_tab[r.dest] = r.sender;
          end
        end else begin
          cost_tab[r.sender] = c;
        end
        for (k = 0; k < NODES; k++) begin
          if (k == r.sender) begin
            age_tab[k] = '0;
            tmo_tab[k] = 1'b0;
          end else if (nbr_mask[k] && age_tab[k] > tmo_limit) begin
            tmo_tab[k] = 1'b1;
          end
        end
      end
      REQ_LINK: cost_tab[r.dest] = c;
      REQ_TICK: begin
        for (k = 0; k < NODES; k++) begin
          if (age_tab[k] != AGE_MAX) age_tab[k] = age_tab[k] + 16'd1;
        end
      end
      default: begin
        e.node = r.dest;
        if (r.dest == my_id) begin
          e.hop = my_id;
          e.cost = '0;
          e.inf = 1'b0;
        end else if (tmo_tab[r.dest]) begin
          // A timed-out destination also loses its stored cost.
          e.hop = hop_tab[r.dest];
          e.cost = COST_INF;
          e.inf = 1'b1;
          cost_tab[r.dest] = COST_INF;
        end else if (cost_tab[r.dest] >= COST_INF) begin
          e.hop = hop_tab[r.dest];
          e.cost = COST_INF;
          e.inf = 1'b1;
        end else begin
          e.hop = hop_tab[r.dest];
          e.cost = cost_tab[r.dest];
          e.inf = 1'b0;
        end
        read_resp_q.push_back(e);
      end
    endcase
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        route_table_step(req_cur);
        accepted_cnt++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap != 0) begin
          s_tvalid <= 1'b0;
          tx_gap--;
        end else if (req_q.size() != 0 && !calm && $urandom_range(0, 9) == 0) begin
          s_tvalid <= 1'b0;
          tx_gap = $urandom_range(0, 17);
        end else if (req_q.size() != 0) begin
          req_cur = req_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {2'b00, req_cur.cost, req_cur.dest, req_cur.sender};
          s_tuser <= req_cur.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver and checker.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (read_resp_q.size() == 0) begin
          report("result beat with no read pending", m_tdata, 0);
        end else begin
          want = read_resp_q.pop_front();
          checked_cnt++;
          if (m_tdata[3:0] != want.node) report("read_node", m_tdata[3:0], want.node);
          if (m_tdata[7:4] != want.hop) report("read_next_hop", m_tdata[7:4], want.hop);
          if (m_tdata[21:8] != want.cost) report("read_cost", m_tdata[21:8], want.cost);
          if (m_tdata[22] != want.inf) report("read_infinite", m_tdata[22], want.inf);
        end
      end
      if (rx_gap != 0) begin
        m_tready <= 1'b0;
        rx_gap--;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        rx_gap = $urandom_range(0, 17);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("distance_vector_table_update_top_test: errors");
      $finish;
    end
  end

  task automatic issue(input req_type_t kind, input logic [3:0] sender,
                       input logic [3:0] dest, input logic [13:0] cost);
    route_req_t r;
    r.kind = kind;
    r.sender = sender;
    r.dest = dest;
    r.cost = cost;
    req_q.push_back(r);
    issued_cnt++;
  endtask

  // Waits until every request is taken and every read answered, then lets
  // the last non-read request finish inside the block.
  task automatic settle();
    while (accepted_cnt != issued_cnt || read_resp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_regs(input logic [3:0] id, input logic [15:0] mask,
                          input logic [15:0] tmo);
    cfg_idx_t idx;
    logic [15:0] val;
    int i;
    for (i = 0; i < 3; i++) begin
      idx = cfg_idx_t'(i);
      val = (idx == CFG_SELF_ID) ? {12'd0, id} : (idx == CFG_NBR_MASK) ? mask : tmo;
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= val;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx)
        CFG_SELF_ID:  my_id = val[3:0];
        CFG_NBR_MASK: nbr_mask = val;
        default:      tmo_limit = val;
      endcase
      reg_writes++;
    end
    cfg_valid <= 1'b0;
    settings_cnt++;
  endtask

  function automatic logic [13:0] pick_cost();
    case ($urandom_range(0, 9))
      0:       return 14'd0;
      1:       return COST_INF;
      2:       return 14'($urandom_range(10001, 16383));
      3, 4:    return 14'($urandom_range(0, 16383));
      default: return 14'($urandom_range(0, 60));
    endcase
  endfunction

  // Mostly well-formed announcements: a neighbor sets its link cost, sends a
  // few entries, time passes, then a destination is read back.
  task automatic random_items(input int n);
    int start;
    logic [3:0] who;
    start = issued_cnt;
    while (issued_cnt - start < n) begin
      if ($urandom_range(0, 3) != 0) begin
        who = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 1) == 1) issue(REQ_LINK, 4'($urandom), who, pick_cost());
        else issue(REQ_ADVERT, who, my_id, 14'($urandom_range(0, 30)));
        repeat ($urandom_range(1, 5)) issue(REQ_ADVERT, who, 4'($urandom), pick_cost());
        repeat ($urandom_range(0, 3)) issue(REQ_TICK, 4'($urandom), 4'($urandom),
                                            14'($urandom));
        issue(REQ_READ, 4'($urandom), 4'($urandom), 14'($urandom));
      end else begin
        issue(req_type_t'($urandom_range(0, 3)), 4'($urandom), 4'($urandom),
              14'($urandom));
      end
    end
  endtask

  initial begin
    int k;
    my_id = 4'd1;
    nbr_mask = '0;
    tmo_limit = 16'd8;
    for (k = 0; k < NODES; k++) begin
      cost_tab[k] = COST_INF;
      hop_tab[k] = 4'(k);
      age_tab[k] = '0;
      tmo_tab[k] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reads against the reset values.
    issue(REQ_READ, 4'd0, 4'd1, 14'd0);
    issue(REQ_READ, 4'd15, 4'd0, 14'd16383);
    settle();

    set_regs(4'd3, 16'h8005, 16'd2);
    issue(REQ_READ, 4'd0, 4'd3, 14'd0);
    issue(REQ_READ, 4'd0, 4'd7, 14'd0);
    issue(REQ_LINK, 4'd0, 4'd0, 14'd5);
    issue(REQ_LINK, 4'd0, 4'd15, 14'd16383);
    issue(REQ_ADVERT, 4'd0, 4'd9, 14'd7);
    issue(REQ_ADVERT, 4'd0, 4'd3, 14'd4);
    // The sender has no route, so the candidate saturates.
    issue(REQ_ADVERT, 4'd15, 4'd9, 14'd0);
    issue(REQ_READ, 4'd0, 4'd9, 14'd0);
    issue(REQ_LINK, 4'd0, 4'd2, 14'd1);
    issue(REQ_ADVERT, 4'd2, 4'd9, 14'd10000);
    issue(REQ_ADVERT, 4'd2, 4'd12, 14'd9999);
    issue(REQ_ADVERT, 4'd2, 4'd12, 14'd3);
    repeat (3) issue(REQ_TICK, 4'd15, 4'd15, 14'd16383);
    // Node 2 and node 15 have aged past the timeout and get flagged here.
    issue(REQ_ADVERT, 4'd0, 4'd5, 14'd16383);
    issue(REQ_READ, 4'd0, 4'd2, 14'd0);
    issue(REQ_READ, 4'd0, 4'd2, 14'd0);
    issue(REQ_READ, 4'd0, 4'd12, 14'd0);
    issue(REQ_READ, 4'd0, 4'd15, 14'd0);
    issue(REQ_ADVERT, 4'd15, 4'd0, 14'd0);
    issue(REQ_READ, 4'd0, 4'd15, 14'd0);
    issue(REQ_READ, 4'd15, 4'd0, 14'd16383);
    settle();

    set_regs(4'd15, 16'hFFFF, 16'd0);
    random_items(160);
    settle();
    set_regs(4'd0, 16'h0000, 16'hFFFF);
    random_items(140);
    settle();
    set_regs(4'($urandom), 16'($urandom), 16'($urandom_range(0, 12)));
    random_items(170);
    settle();
    set_regs(4'($urandom), 16'($urandom), 16'($urandom_range(1, 40)));
    random_items(170);
    settle();

    calm = 1'b1;
    set_regs(4'($urandom), 16'($urandom), 16'($urandom_range(0, 20)));
    random_items(150);
    settle();

    // Let every neighbor go silent past a short timeout, refresh one route
    // and read the whole table back.
    set_regs(4'($urandom), 16'hFFFF, 16'd4);
    repeat (6) issue(REQ_TICK, 4'($urandom), 4'($urandom), 14'($urandom));
    issue(REQ_LINK, 4'd0, 4'd6, 14'd3);
    issue(REQ_ADVERT, 4'd6, 4'd9, 14'd2);
    for (k = 0; k < NODES; k++) issue(REQ_READ, 4'd0, 4'(k), 14'd0);
    settle();

    $display("%0d requests sent, %0d read results checked", accepted_cnt, checked_cnt);
    $display("%0d register writes across %0d settings, %0d mismatches",
             reg_writes, settings_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("distance_vector_table_update_top_test: clean");
    end else begin
      $display("distance_vector_table_update_top_test: errors");
    end
    $finish;
  end

endmodule
